### hdl/sgs_pkg.sv
// shared types, codes and constants for the servo gait sequencer
package sgs_pkg;

   localparam int TIME_BITS  = 32;
   localparam int ANGLE_W    = 8;
   localparam int SWING_W    = 6;
   localparam int PERIOD_W   = 8;
   localparam int LOCKOUT_W  = 16;
   localparam int HOLD_W     = 16;
   localparam int MODE_W     = 3;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // request opcodes
   localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
   localparam logic [OP_W-1:0] OP_CHANGE   = 2'd1;
   localparam logic [OP_W-1:0] OP_OVERRIDE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

   // gait modes
   localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FORWARD    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BACKWARD   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TURN_RIGHT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TURN_LEFT  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SWING   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT = 2'd2;

   // angle constants in degrees
   localparam logic [ANGLE_W-1:0] ANG_LIFT_REST  = 8'd90;
   localparam logic [ANGLE_W-1:0] ANG_FOOT_REST  = 8'd135;
   localparam logic [ANGLE_W-1:0] ANG_TURN_EXTRA = 8'd30;
   localparam logic [ANGLE_W-1:0] ANG_BACK_LEFT  = 8'd100;
   localparam logic [ANGLE_W-1:0] ANG_BACK_RIGHT = 8'd80;

   // register reset values
   localparam logic [SWING_W-1:0]   SWING_RESET   = 6'd45;
   localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 8'd3;
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd2000;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [MODE_W-1:0] new_mode;
      logic [HOLD_W-1:0] hold_ms;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] left_lift_angle;
      logic [ANGLE_W-1:0] right_lift_angle;
      logic [ANGLE_W-1:0] left_foot_angle;
      logic [ANGLE_W-1:0] right_foot_angle;
      logic [MODE_W-1:0]  mode_now;
      logic               lockout_active;
      logic               accepted;
      logic               stepped;
   } rsp_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] lift_left;
      logic [ANGLE_W-1:0] foot_left;
      logic [ANGLE_W-1:0] lift_right;
      logic [ANGLE_W-1:0] foot_right;
   } angles_type;

endpackage

### hdl/sgs_gait.sv
// one gait step: next servo angles and swing reversal for the current mode
module sgs_gait (
   input  logic [sgs_pkg::MODE_W-1:0]  mode,
   input  logic [sgs_pkg::SWING_W-1:0] swing_deg,
   input  logic                        swing_down,
   input  sgs_pkg::angles_type         cur,
   output sgs_pkg::angles_type         nxt,
   output logic                        flip
);

   function automatic logic [sgs_pkg::ANGLE_W-1:0] clamp_ang(
      input logic [sgs_pkg::ANGLE_W-1:0] x,
      input logic [sgs_pkg::ANGLE_W-1:0] lo,
      input logic [sgs_pkg::ANGLE_W-1:0] hi
   );
      logic [sgs_pkg::ANGLE_W-1:0] r;
      if (x < lo) r = lo;
      else if (x > hi) r = hi;
      else r = x;
      return r;
   endfunction

   function automatic logic [sgs_pkg::ANGLE_W-1:0] toward(
      input logic [sgs_pkg::ANGLE_W-1:0] x,
      input logic [sgs_pkg::ANGLE_W-1:0] rest
   );
      logic [sgs_pkg::ANGLE_W-1:0] r;
      if (x < rest) r = x + 8'd1;
      else if (x > rest) r = x - 8'd1;
      else r = x;
      return r;
   endfunction

   logic [sgs_pkg::ANGLE_W-1:0] sw;
   logic [sgs_pkg::ANGLE_W-1:0] fwd_top;
   logic [sgs_pkg::ANGLE_W-1:0] foot_hi;
   logic [sgs_pkg::ANGLE_W-1:0] right_lo;
   logic [sgs_pkg::ANGLE_W-1:0] back_lo;
   logic [sgs_pkg::ANGLE_W-1:0] back_hi;
   logic [sgs_pkg::ANGLE_W-1:0] c_ll;
   logic [sgs_pkg::ANGLE_W-1:0] c_fl;
   logic [sgs_pkg::ANGLE_W-1:0] c_lr;
   logic [sgs_pkg::ANGLE_W-1:0] c_fr;
   logic [sgs_pkg::ANGLE_W-1:0] b_ll;
   logic [sgs_pkg::ANGLE_W-1:0] b_lr;
   logic [sgs_pkg::ANGLE_W-1:0] f_ll;
   logic [sgs_pkg::ANGLE_W-1:0] r_ll;

   assign sw       = {2'b00, swing_deg};
   assign fwd_top  = (mode == sgs_pkg::MODE_FORWARD)
                     ? sgs_pkg::ANG_LIFT_REST + sw
                     : sgs_pkg::ANG_LIFT_REST + sw + sgs_pkg::ANG_TURN_EXTRA;
   assign foot_hi  = sgs_pkg::ANG_FOOT_REST + sw;
   assign right_lo = sgs_pkg::ANG_LIFT_REST - sw;
   assign back_lo  = sgs_pkg::ANG_BACK_LEFT - sw;
   assign back_hi  = sgs_pkg::ANG_BACK_RIGHT + sw;

   // clamped angles for the walking modes
   assign c_fl = clamp_ang(cur.foot_left, sgs_pkg::ANG_FOOT_REST, foot_hi);
   assign c_fr = clamp_ang(cur.foot_right, right_lo, sgs_pkg::ANG_LIFT_REST);
   assign f_ll = clamp_ang(cur.lift_left, sgs_pkg::ANG_LIFT_REST, fwd_top);
   assign c_lr = clamp_ang(cur.lift_right, right_lo, sgs_pkg::ANG_LIFT_REST);
   assign b_ll = clamp_ang(cur.lift_left, back_lo, sgs_pkg::ANG_BACK_LEFT);
   assign b_lr = clamp_ang(cur.lift_right, sgs_pkg::ANG_BACK_RIGHT, back_hi);

   // left lift after the swing move
   assign c_ll = (mode == sgs_pkg::MODE_BACKWARD) ? b_ll : f_ll;
   assign r_ll = swing_down ? c_ll - 8'd1 : c_ll + 8'd1;

   always_comb begin
      nxt  = cur;
      flip = 1'b0;
      case (mode)
         sgs_pkg::MODE_IDLE: begin
            nxt.lift_left  = toward(cur.lift_left, sgs_pkg::ANG_LIFT_REST);
            nxt.foot_left  = toward(cur.foot_left, sgs_pkg::ANG_FOOT_REST);
            nxt.lift_right = toward(cur.lift_right, sgs_pkg::ANG_LIFT_REST);
            nxt.foot_right = toward(cur.foot_right, sgs_pkg::ANG_LIFT_REST);
         end
         sgs_pkg::MODE_FORWARD, sgs_pkg::MODE_TURN_RIGHT: begin
            nxt.lift_left  = r_ll;
            nxt.foot_left  = swing_down ? c_fl - 8'd2 : c_fl + 8'd1;
            nxt.lift_right = swing_down ? c_lr - 8'd1 : c_lr + 8'd1;
            nxt.foot_right = swing_down ? c_fr - 8'd1 : c_fr + 8'd2;
            flip = (r_ll >= fwd_top) || (r_ll <= sgs_pkg::ANG_LIFT_REST);
         end
         sgs_pkg::MODE_BACKWARD: begin
            nxt.lift_left  = r_ll;
            nxt.foot_left  = swing_down ? c_fl + 8'd1 : c_fl - 8'd2;
            nxt.lift_right = swing_down ? b_lr - 8'd1 : b_lr + 8'd1;
            nxt.foot_right = swing_down ? c_fr + 8'd2 : c_fr - 8'd1;
            flip = (r_ll <= back_lo) || (r_ll >= sgs_pkg::ANG_BACK_LEFT);
         end
         default: begin
            nxt  = cur;
            flip = 1'b0;
         end
      endcase
   end

endmodule

### hdl/servo_gait_sequencer_unit.sv
// servo gait sequencer top level: request register, timers, mode and angle state
//
// usage
//   req channel: one word per item (tick, guarded mode change or forced override)
//   rsp channel: one word per item with the four servo angles, the mode, the
//     lockout flag and the accepted and stepped flags after that item
//   csr channel: register index and data; always ready, writes land at once and
//     are meant to be made while no item is in flight
// response path: an accepted req word is held in the request register, then the
//   state update writes its rsp word into the response register
// throughput: one word per cycle while rsp is not held off; the state update for
//   an item is one pass through the timer compares and the gait step logic
// reset: synchronous; registers go to their defaults, the clock and all
//   deadlines to zero, mode idle, angles 90 / 135 / 45 / 45, swing upward
// stall: while rsp is held off the response register keeps its word and the
//   request register can still take one more word; req_ready then drops
//   until rsp_ready returns
module servo_gait_sequencer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sgs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sgs_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgs_pkg::CSR_DATA_W-1:0]      csr_data
);

   // configuration registers
   logic [sgs_pkg::SWING_W-1:0]   swing_ff;
   logic [sgs_pkg::PERIOD_W-1:0]  period_ff;
   logic [sgs_pkg::LOCKOUT_W-1:0] lockout_ms_ff;

   // request stage
   logic                          req_vld_ff;
   sgs_pkg::req_type              req_item_ff;
   logic                          advance;

   // response stage
   logic                          rsp_vld_ff;
   sgs_pkg::rsp_type              rsp_data_ff;
   sgs_pkg::rsp_type              rsp_data_in;

   // timing state
   logic [sgs_pkg::TIME_BITS-1:0] now_ff;
   logic [sgs_pkg::TIME_BITS-1:0] now_next_ff;
   logic [sgs_pkg::TIME_BITS-1:0] next_step_ff;
   logic [sgs_pkg::TIME_BITS-1:0] lock_dl_ff;
   logic [sgs_pkg::TIME_BITS-1:0] hold_dl_ff;
   logic                          lockout_ff;
   logic                          hold_ff;
   logic [sgs_pkg::MODE_W-1:0]    mode_ff;
   sgs_pkg::angles_type           angles_ff;
   logic                          swing_down_ff;

   logic [sgs_pkg::TIME_BITS-1:0] now_in;
   logic [sgs_pkg::TIME_BITS-1:0] now_next_in;
   logic [sgs_pkg::TIME_BITS-1:0] next_step_in;
   logic [sgs_pkg::TIME_BITS-1:0] lock_dl_in;
   logic [sgs_pkg::TIME_BITS-1:0] hold_dl_in;
   logic                          lockout_in;
   logic                          hold_in;
   logic [sgs_pkg::MODE_W-1:0]    mode_in;
   sgs_pkg::angles_type           angles_in;
   logic                          swing_down_in;

   logic [sgs_pkg::MODE_W-1:0]    tick_mode;
   logic                          step_due;
   logic                          accepted;
   logic                          stepped;
   sgs_pkg::angles_type           gait_angles;
   logic                          gait_flip;
   logic [sgs_pkg::TIME_BITS-1:0] lock_dl_new;

   assign csr_ready = 1'b1;
   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         swing_ff      <= sgs_pkg::SWING_RESET;
         period_ff     <= sgs_pkg::PERIOD_RESET;
         lockout_ms_ff <= sgs_pkg::LOCKOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sgs_pkg::CSR_SWING:   swing_ff      <= csr_data[sgs_pkg::SWING_W-1:0];
            sgs_pkg::CSR_PERIOD:  period_ff     <= csr_data[sgs_pkg::PERIOD_W-1:0];
            sgs_pkg::CSR_LOCKOUT: lockout_ms_ff <= csr_data[sgs_pkg::LOCKOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_ready) begin
         req_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_item_ff <= req_data;
      end
   end

   // tick decisions use the incremented clock held in now_next_ff
   assign tick_mode = (hold_ff && (now_next_ff > hold_dl_ff)) ? sgs_pkg::MODE_IDLE : mode_ff;
   assign step_due  = now_next_ff > next_step_ff;
   assign lock_dl_new = now_ff + sgs_pkg::TIME_BITS'(lockout_ms_ff);

   sgs_gait u_gait (
      .mode       (tick_mode),
      .swing_deg  (swing_ff),
      .swing_down (swing_down_ff),
      .cur        (angles_ff),
      .nxt        (gait_angles),
      .flip       (gait_flip)
   );

   always_comb begin
      now_in        = now_ff;
      now_next_in   = now_next_ff;
      next_step_in  = next_step_ff;
      lock_dl_in    = lock_dl_ff;
      hold_dl_in    = hold_dl_ff;
      lockout_in    = lockout_ff;
      hold_in       = hold_ff;
      mode_in       = mode_ff;
      angles_in     = angles_ff;
      swing_down_in = swing_down_ff;
      accepted      = 1'b0;
      stepped       = 1'b0;
      case (req_item_ff.op)
         sgs_pkg::OP_TICK: begin
            now_in      = now_next_ff;
            now_next_in = now_next_ff + sgs_pkg::TIME_BITS'(1);
            if (lockout_ff && (now_next_ff > lock_dl_ff)) begin
               lockout_in = 1'b0;
            end
            if (hold_ff && (now_next_ff > hold_dl_ff)) begin
               hold_in = 1'b0;
            end
            mode_in = tick_mode;
            if (step_due) begin
               angles_in     = gait_angles;
               swing_down_in = swing_down_ff ^ gait_flip;
               stepped       = 1'b1;
               next_step_in  = now_next_ff + sgs_pkg::TIME_BITS'(period_ff);
            end
         end
         sgs_pkg::OP_CHANGE: begin
            if (!lockout_ff && (mode_ff != req_item_ff.new_mode)) begin
               mode_in    = req_item_ff.new_mode;
               lockout_in = 1'b1;
               lock_dl_in = lock_dl_new;
               hold_dl_in = now_ff + sgs_pkg::TIME_BITS'(req_item_ff.hold_ms);
               hold_in    = 1'b1;
               accepted   = 1'b1;
            end
         end
         sgs_pkg::OP_OVERRIDE: begin
            mode_in    = req_item_ff.new_mode;
            lockout_in = 1'b1;
            lock_dl_in = lock_dl_new;
            accepted   = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data_in.left_lift_angle  = angles_in.lift_left;
      rsp_data_in.right_lift_angle = angles_in.lift_right;
      rsp_data_in.left_foot_angle  = angles_in.foot_left;
      rsp_data_in.right_foot_angle = angles_in.foot_right;
      rsp_data_in.mode_now         = mode_in;
      rsp_data_in.lockout_active   = lockout_in;
      rsp_data_in.accepted         = accepted;
      rsp_data_in.stepped          = stepped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         now_next_ff   <= sgs_pkg::TIME_BITS'(1);
         next_step_ff  <= '0;
         lock_dl_ff    <= '0;
         hold_dl_ff    <= '0;
         lockout_ff    <= 1'b0;
         hold_ff       <= 1'b0;
         mode_ff       <= sgs_pkg::MODE_IDLE;
         angles_ff.lift_left  <= sgs_pkg::ANG_LIFT_REST;
         angles_ff.foot_left  <= sgs_pkg::ANG_FOOT_REST;
         angles_ff.lift_right <= sgs_pkg::ANG_LIFT_REST - {2'b00, sgs_pkg::SWING_RESET};
         angles_ff.foot_right <= sgs_pkg::ANG_LIFT_REST - {2'b00, sgs_pkg::SWING_RESET};
         swing_down_ff <= 1'b0;
      end else if (advance) begin
         now_ff        <= now_in;
         now_next_ff   <= now_next_in;
         next_step_ff  <= next_step_in;
         lock_dl_ff    <= lock_dl_in;
         hold_dl_ff    <= hold_dl_in;
         lockout_ff    <= lockout_in;
         hold_ff       <= hold_in;
         mode_ff       <= mode_in;
         angles_ff     <= angles_in;
         swing_down_ff <= swing_down_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // incremented clock copy tracks the clock
   assert property (@(posedge clock) disable iff (reset)
      now_next_ff == now_ff + sgs_pkg::TIME_BITS'(1))
      else $error("incremented clock copy out of step");

   // a tick never reports an accepted request
   assert property (@(posedge clock) disable iff (reset)
      advance && (req_item_ff.op == sgs_pkg::OP_TICK) |=> !rsp_data_ff.accepted)
      else $error("tick reported as accepted");

   // only ticks can run a gait step
   assert property (@(posedge clock) disable iff (reset)
      advance && (req_item_ff.op != sgs_pkg::OP_TICK) |=> !rsp_data_ff.stepped)
      else $error("gait step on a request");

   // an override always takes the new mode and starts a lockout
   assert property (@(posedge clock) disable iff (reset)
      advance && (req_item_ff.op == sgs_pkg::OP_OVERRIDE) |=>
         rsp_data_ff.accepted && rsp_data_ff.lockout_active &&
         (rsp_data_ff.mode_now == $past(req_item_ff.new_mode)))
      else $error("override did not take effect");

   // the unused opcode leaves the mode and flags alone
   assert property (@(posedge clock) disable iff (reset)
      advance && (req_item_ff.op == sgs_pkg::OP_UNUSED) |=>
         $stable(mode_ff) && !rsp_data_ff.accepted && !rsp_data_ff.stepped)
      else $error("unused opcode changed state");

endmodule
